// ----- sv/mtf_pkg.sv -----
package mtf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths on the channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_FIND = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Controller -> datapath strobes
  typedef struct packed {
    logic capture;   // latch request beat
    logic search;    // register compare vector
    logic update;    // commit list / count
    logic load_rsp;  // fill response register
  } ctrl_t;

endpackage

// ----- sv/mtf_req_if.sv -----
interface mtf_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [mtf_pkg::CMD_W-1:0]        command;
  logic signed [mtf_pkg::VALUE_W-1:0]      value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- sv/mtf_rsp_if.sv -----
interface mtf_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    hit;
  logic        [mtf_pkg::POS_W-1:0]        hit_position;
  logic        [mtf_pkg::STATUS_W-1:0]     status;
  logic        [mtf_pkg::COUNT_W-1:0]      entry_count;
  logic signed [mtf_pkg::VALUE_W-1:0]      front_value;

  modport source (output valid, output hit, output hit_position, output status,
                  output entry_count, output front_value, input ready);
  modport sink   (input valid, input hit, input hit_position, input status,
                  input entry_count, input front_value, output ready);
endinterface

// ----- sv/mtf_ctrl.sv -----
module mtf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output mtf_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_REPORT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   load;

  // response slot free or draining this cycle
  assign load = (state_q == ST_REPORT) && (!rsp_valid_q || rsp_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (req_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_REPORT;
      ST_REPORT: if (load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o     = (state_q == ST_IDLE);
  assign rsp_valid_o     = rsp_valid_q;
  assign ctrl_o.capture  = req_valid_i && (state_q == ST_IDLE);
  assign ctrl_o.search   = (state_q == ST_SEARCH);
  assign ctrl_o.update   = (state_q == ST_UPDATE);
  assign ctrl_o.load_rsp = load;

endmodule

// ----- sv/mtf_datapath.sv -----
module mtf_datapath #(
  parameter int unsigned DEPTH      = mtf_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = mtf_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtf_pkg::ctrl_t                    ctrl_i,
  input  logic [mtf_pkg::CMD_W-1:0]         command_i,
  input  logic [mtf_pkg::VALUE_W-1:0]       value_i,
  output logic                              hit_o,
  output logic [mtf_pkg::POS_W-1:0]         hit_position_o,
  output logic [mtf_pkg::STATUS_W-1:0]      status_o,
  output logic [mtf_pkg::COUNT_W-1:0]       entry_count_o,
  output logic [mtf_pkg::VALUE_W-1:0]       front_value_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // list cells, slot 0 is the front
  logic [VALUE_BITS-1:0] entries_q [DEPTH];
  logic [VALUE_BITS-1:0] entries_d [DEPTH];
  logic [CW-1:0]         count_q, count_d;

  logic [mtf_pkg::CMD_W-1:0] cmd_q;
  logic [VALUE_BITS-1:0]     val_q;
  logic [63:0]               val_ext;
  logic [DEPTH-1:0]          match_q, match_d;

  logic                   hit_q, hit_d;
  logic [IW-1:0]          pos_q, pos_d;
  mtf_pkg::status_e       status_q, status_d;

  logic [DEPTH-1:0]       match_m1, upto_hit, first_hit;
  logic                   any_hit;
  logic                   full, empty;

  logic                              rsp_hit_q;
  logic [mtf_pkg::POS_W-1:0]         rsp_pos_q;
  logic [mtf_pkg::STATUS_W-1:0]      rsp_status_q;
  logic [mtf_pkg::COUNT_W-1:0]       rsp_count_q;
  logic [mtf_pkg::VALUE_W-1:0]       rsp_front_q;

  logic [IW+mtf_pkg::POS_W-1:0]      pos_wide;
  logic [CW+mtf_pkg::COUNT_W-1:0]    count_wide;
  logic [VALUE_BITS+mtf_pkg::VALUE_W-1:0] front_wide;

  // sign-extend the 32-bit value, keep VALUE_BITS
  assign val_ext = {{32{value_i[mtf_pkg::VALUE_W-1]}}, value_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      val_q <= val_ext[VALUE_BITS-1:0];
    end
  end

  // parallel compare over the live cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (entries_q[i] == val_q) && (CW'(i) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.search) match_q <= match_d;
  end

  // first hit: lowest set bit; upto_hit covers slots 0..hit
  assign match_m1  = match_q - DEPTH'(1);
  assign upto_hit  = match_q ^ match_m1;
  assign first_hit = match_q & ~match_m1;
  assign any_hit   = |match_q;
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    hit_d     = 1'b0;
    pos_d     = '0;
    status_d  = mtf_pkg::STAT_OK;
    case (cmd_q)
      mtf_pkg::CMD_PUSH: begin
        if (full) begin
          status_d = mtf_pkg::STAT_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) entries_d[i] = entries_q[i-1];
          entries_d[0] = val_q;
          count_d      = count_q + CW'(1);
        end
      end
      mtf_pkg::CMD_POP: begin
        if (empty) begin
          status_d = mtf_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) entries_d[i] = entries_q[i+1];
          count_d = count_q - CW'(1);
        end
      end
      mtf_pkg::CMD_FIND: begin
        if (any_hit) begin
          hit_d = 1'b1;
          for (int i = 1; i < DEPTH; i++) begin
            if (upto_hit[i]) entries_d[i] = entries_q[i-1];
          end
          entries_d[0] = val_q;
          for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) pos_d = pos_d | IW'(i);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      entries_q <= entries_d;
      hit_q     <= hit_d;
      pos_q     <= pos_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.update) begin
      count_q <= count_d;
    end
  end

  // fields trimmed to channel widths
  assign pos_wide   = {{mtf_pkg::POS_W{1'b0}}, pos_q};
  assign count_wide = {{mtf_pkg::COUNT_W{1'b0}}, count_q};
  assign front_wide = empty ? '0 : {{mtf_pkg::VALUE_W{1'b0}}, entries_q[0]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_rsp) begin
      rsp_hit_q    <= hit_q;
      rsp_pos_q    <= pos_wide[mtf_pkg::POS_W-1:0];
      rsp_status_q <= status_q;
      rsp_count_q  <= count_wide[mtf_pkg::COUNT_W-1:0];
      rsp_front_q  <= front_wide[mtf_pkg::VALUE_W-1:0];
    end
  end

  assign hit_o          = rsp_hit_q;
  assign hit_position_o = rsp_pos_q;
  assign status_o       = rsp_status_q;
  assign entry_count_o  = rsp_count_q;
  assign front_value_o  = rsp_front_q;

endmodule

// ----- sv/move_to_front_list.sv -----
// Move-to-front list of up to DEPTH values (VALUE_BITS each). A request beat carries a
// command (push, pop, find) and a value; each one yields exactly one response beat with
// hit, hit_position, status, entry_count and front_value. Between acceptance and a loaded
// response a request is latched, then all list cells are compared in parallel (registered
// match vector), then the cells are shifted and the count is committed, then the response
// register is filled. The next request is accepted in the cycle after the response register
// is loaded, so the block takes no new request while one is in flight; a stalled response
// holds the block in its last step. Cells that were never written hold no defined value
// and are never reported.
module move_to_front_list #(
  parameter int unsigned DEPTH      = mtf_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = mtf_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtf_req_if.sink    req_i,
  mtf_rsp_if.source  rsp_o
);

  mtf_pkg::ctrl_t ctrl;

  // sequencer: idle -> compare -> shift -> respond
  mtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // list cells, compare row, count and response register
  mtf_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .command_i      (req_i.command),
    .value_i        (req_i.value),
    .hit_o          (rsp_o.hit),
    .hit_position_o (rsp_o.hit_position),
    .status_o       (rsp_o.status),
    .entry_count_o  (rsp_o.entry_count),
    .front_value_o  (rsp_o.front_value)
  );

`ifndef ASSERT_OFF
  // one request in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while previous one in flight");

  // a hit never comes with an error status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> rsp_o.status == mtf_pkg::STAT_OK)
    else $error("hit reported with error status");

  // refused push only on a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == mtf_pkg::STAT_FULL
      |-> rsp_o.entry_count == mtf_pkg::COUNT_W'(DEPTH))
    else $error("full status with list not full");

  // pop on empty reports an empty list
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == mtf_pkg::STAT_EMPTY
      |-> rsp_o.entry_count == '0 && rsp_o.front_value == '0)
    else $error("empty status with entries present");
`endif

endmodule
